/* hdl/ios_pkg.sv */
// ----------------------------------------------------------------------------
// ios_pkg - shared definitions for the insertion-ordered set
// Sizes, command and status codes, and the control word of one storage cell.
// ----------------------------------------------------------------------------
package ios_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 8;
    localparam int VALUE_W  = 8;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int CMD_W    = 3;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(POS_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_TAKE   = 3'd3,
        CMD_QUERY  = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE     = 3'd0,
        STS_DUP      = 3'd1,
        STS_NOTFOUND = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

/* hdl/ios_cell.sv */
// ----------------------------------------------------------------------------
// ios_cell - one storage cell of the set
// Holds one entry, compares it with the search value, and either loads a
// new value or takes over the entry of its right-hand neighbour.
// ----------------------------------------------------------------------------
module ios_cell (
    input  logic                       i_clk,
    input  ios_pkg::t_cell_ctl         i_ctl,
    input  logic [ios_pkg::ELEM_W-1:0] i_value,
    input  logic [ios_pkg::ELEM_W-1:0] i_next,
    output logic [ios_pkg::ELEM_W-1:0] o_entry,
    output logic                       o_match
);
    import ios_pkg::*;

    logic [ELEM_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_value;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_value);

endmodule

/* hdl/ios_mod.sv */
// ----------------------------------------------------------------------------
// ios_mod - serial remainder unit
// Restoring division of the position by the element count, one dividend
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ios_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ios_pkg::POS_W-1:0] i_dividend,
    input  logic [ios_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [ios_pkg::CNT_W-1:0] o_rem
);
    import ios_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic [CNT_W-1:0]  n_rem;

    // The partial remainder stays below the divisor, so one extra bit is enough.
    assign trial = {r_rem, r_dvd[POS_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign n_rem = (trial >= {1'b0, r_dsr}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(POS_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[POS_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_step == STEP_W'(POS_W - 1));
    assign o_rem  = r_rem;

endmodule

/* hdl/insertion_ordered_set_core.sv */
// ----------------------------------------------------------------------------
// insertion_ordered_set_core - set of distinct values kept in insertion order
// Add, delete, query, clear and an empty peek or take go from the accepted
// beat through the search and execute states to a registered result; peek
// and take on a non-empty set wait in the divide state between the two while
// a serial remainder unit reduces the 16-bit position bit by bit. A new beat
// is taken only after the execute state has handed its result on.
// One command is worked on at a time; the result register frees the input side.
// Reset clears the count and all control state; the cells keep stale values.
// ----------------------------------------------------------------------------
module insertion_ordered_set_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ios_pkg::CMD_W-1:0]    i_command,
    input  logic [ios_pkg::VALUE_W-1:0]  i_value,
    input  logic [ios_pkg::POS_W-1:0]    i_position,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ios_pkg::STATUS_W-1:0] o_status,
    output logic [ios_pkg::VALUE_W-1:0]  o_value_out,
    output logic                         o_is_member,
    output logic [ios_pkg::COUNT_W-1:0]  o_count
);
    import ios_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_DIV    = 4'b0100,
        S_EXEC   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [ELEM_W-1:0] r_value;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic [CAPACITY-1:0] r_hit;

    logic                r_out_valid;
    t_status             r_status;
    logic [VALUE_W-1:0]  r_vout;
    logic                r_member;
    logic [CNT_W-1:0]    r_out_count;

    logic [ELEM_W-1:0]   entry [CAPACITY];
    logic [CAPACITY-1:0] match;
    t_cell_ctl           ctl [CAPACITY];

    logic              in_acc;
    logic              exec_go;
    logic              div_start;
    logic              div_done;
    logic [CNT_W-1:0]  div_rem;
    logic [IDX_W-1:0]  div_idx;
    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic              is_full;
    logic              is_empty;

    t_status           sts;
    logic [VALUE_W-1:0] vout;
    logic              member;
    logic [CNT_W-1:0]  cnt_nx;
    logic              do_add;
    logic              do_rm;
    logic [IDX_W-1:0]  rm_idx;

    // Row of cells; on removal the cells from the removed slot up shift in from their right-hand neighbour.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_W-1:0] nxt;
        if (g == CAPACITY - 1) begin : g_last
            assign nxt = entry[g];
        end else begin : g_mid
            assign nxt = entry[g+1];
        end
        ios_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl[g]),
            .i_value (r_value),
            .i_next  (nxt),
            .o_entry (entry[g]),
            .o_match (match[g])
        );
    end

    assign div_start = (r_state == S_SEARCH) &&
                       ((r_cmd == CMD_PEEK) || (r_cmd == CMD_TAKE)) && !is_empty;

    ios_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_pos),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign div_idx  = div_rem[IDX_W-1:0];
    assign in_acc   = i_in_valid && !o_in_stall;
    assign exec_go  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign hit_any  = |r_hit;

    // Values are distinct, so at most one hit bit is set.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_hit[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        sts    = STS_DONE;
        vout   = '0;
        member = 1'b0;
        cnt_nx = r_count;
        do_add = 1'b0;
        do_rm  = 1'b0;
        rm_idx = hit_idx;
        case (r_cmd)
            CMD_ADD: begin
                if (hit_any) begin
                    sts = STS_DUP;
                end else if (is_full) begin
                    sts = STS_FULL;
                end else begin
                    do_add = 1'b1;
                    vout   = VALUE_W'(r_value);
                    cnt_nx = r_count + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!hit_any) begin
                    sts = STS_NOTFOUND;
                end else begin
                    do_rm  = 1'b1;
                    vout   = VALUE_W'(r_value);
                    cnt_nx = r_count - 1'b1;
                end
            end
            CMD_PEEK, CMD_TAKE: begin
                if (is_empty) begin
                    sts = STS_EMPTY;
                end else begin
                    vout = VALUE_W'(entry[div_idx]);
                    if (r_cmd == CMD_TAKE) begin
                        do_rm  = 1'b1;
                        rm_idx = div_idx;
                        cnt_nx = r_count - 1'b1;
                    end
                end
            end
            CMD_QUERY: begin
                member = hit_any;
            end
            CMD_CLEAR: begin
                cnt_nx = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ctl[i].load  = exec_go && do_add && (r_count == CNT_W'(i));
            ctl[i].shift = exec_go && do_rm && (IDX_W'(i) >= rm_idx);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_state = div_start ? S_DIV : S_EXEC;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_count     <= cnt_nx;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= t_cmd'(i_command);
            r_value <= i_value[ELEM_W-1:0];
            r_pos   <= i_position;
        end
        // Only entries below the count take part in the search.
        if (r_state == S_SEARCH) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_hit[i] <= match[i] && (CNT_W'(i) < r_count);
            end
        end
        if (exec_go) begin
            r_status    <= sts;
            r_vout      <= vout;
            r_member    <= member;
            r_out_count <= cnt_nx;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_is_member = r_member;
    assign o_count     = COUNT_W'(r_out_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && i_out_stall) |=> $stable(r_count))
        else $error("count changed while the result register was blocked");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder finished outside its wait state");

    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SEARCH))
        else $error("accepted beat did not start a search");

endmodule

/* tb/tb_insertion_ordered_set_core.sv */
// ----------------------------------------------------------------------------
// tb_insertion_ordered_set_core - self-checking bench for the ordered set core
// Commands are driven over a valid/stall channel and each accepted beat is
// predicted by a scoreboard that keeps its own copy of the set. Replies are
// compared field by field under random source gaps and sink stalls, and the
// sink holds off for one long stretch so that the core backs up.
// ----------------------------------------------------------------------------
module tb_insertion_ordered_set_core;

    import ios_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 25;
    localparam int PHASE_ITEMS  = 288;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic                member;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    class set_scoreboard;
        logic [VALUE_W-1:0] slots[CAPACITY];
        int unsigned        fill;
        t_reply             expected_replies[$];
        int unsigned        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int find_slot(logic [VALUE_W-1:0] val);
            for (int i = 0; i < fill; i++) begin
                if (slots[i] == val) return i;
            end
            return -1;
        endfunction

        function void remove_slot(int unsigned idx);
            for (int unsigned i = idx; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            t_reply      rep;
            int          at;
            int unsigned idx;
            rep.status = STS_DONE;
            rep.value  = '0;
            rep.member = 1'b0;
            case (cmd)
                CMD_ADD: begin
                    if (find_slot(val) >= 0) begin
                        rep.status = STS_DUP;
                    end else if (fill >= CAPACITY) begin
                        rep.status = STS_FULL;
                    end else begin
                        slots[fill] = val;
                        fill++;
                        rep.value = val;
                    end
                end
                CMD_DELETE: begin
                    at = find_slot(val);
                    if (at < 0) begin
                        rep.status = STS_NOTFOUND;
                    end else begin
                        remove_slot(at);
                        rep.value = val;
                    end
                end
                CMD_PEEK, CMD_TAKE: begin
                    if (fill == 0) begin
                        rep.status = STS_EMPTY;
                    end else begin
                        idx = int'(pos) % fill;
                        rep.value = slots[idx];
                        if (cmd == CMD_TAKE) remove_slot(idx);
                    end
                end
                CMD_QUERY: rep.member = (find_slot(val) >= 0);
                CMD_CLEAR: fill = 0;
                default: ;
            endcase
            rep.count = COUNT_W'(fill);
            expected_replies.push_back(rep);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                                  logic member, logic [COUNT_W-1:0] count);
            t_reply rep;
            if (expected_replies.size() == 0) begin
                $display("%0t: reply beat with nothing expected (status %0d value %0d)",
                         $time, status, value);
                errors++;
                return;
            end
            rep = expected_replies.pop_front();
            if (status !== rep.status) begin
                $display("%0t: status expected %0d, got %0d", $time, rep.status, status);
                errors++;
            end
            if (value !== rep.value) begin
                $display("%0t: value expected %0d, got %0d", $time, rep.value, value);
                errors++;
            end
            if (member !== rep.member) begin
                $display("%0t: is_member expected %0d, got %0d", $time, rep.member, member);
                errors++;
            end
            if (count !== rep.count) begin
                $display("%0t: count expected %0d, got %0d", $time, rep.count, count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [VALUE_W-1:0]  i_value;
    logic [POS_W-1:0]    i_position;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [VALUE_W-1:0]  o_value_out;
    logic                o_is_member;
    logic [COUNT_W-1:0]  o_count;

    set_scoreboard sb = new();

    int unsigned sender_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned cycle_count;
    bit          hold_active;
    event        long_hold;

    insertion_ordered_set_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_is_member (o_is_member),
        .o_count     (o_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_insertion_ordered_set_core: FAIL");
            $finish;
        end
    end

    // The long hold-off is timed here so the sender can keep offering beats.
    initial begin
        hold_active = 1'b0;
        forever begin
            @(long_hold);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= hold_active ||
                       (sink_stall_pct != 0 && $urandom_range(99, 0) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reply(o_status, o_value_out, o_is_member, o_count);
    end

    // Valid stays high after a beat is taken; the next falling edge either
    // lowers it for a gap or puts the next beat on the bus.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        @(negedge i_clk);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(cmd, val, pos);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(bit fill_mix);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (fill_mix) begin
            if (r < 50) return CMD_ADD;
            if (r < 60) return CMD_DELETE;
            if (r < 72) return CMD_PEEK;
            if (r < 78) return CMD_TAKE;
            if (r < 94) return CMD_QUERY;
            if (r < 96) return CMD_CLEAR;
        end else begin
            if (r < 28) return CMD_ADD;
            if (r < 48) return CMD_DELETE;
            if (r < 63) return CMD_PEEK;
            if (r < 83) return CMD_TAKE;
            if (r < 94) return CMD_QUERY;
            if (r < 96) return CMD_CLEAR;
        end
        return (r[0]) ? CMD_RSVD_A : CMD_RSVD_B;
    endfunction

    task automatic send_random(input bit fill_mix);
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
        // A narrow pool larger than the capacity gives duplicates, hits on
        // delete and a full set, while the wide draws reach every value bit.
        if ($urandom_range(3, 0) != 0) val = VALUE_W'($urandom_range(23, 0));
        else                          val = VALUE_W'($urandom_range(255, 0));
        case ($urandom_range(4, 0))
            0:       pos = '0;
            1:       pos = '1;
            2, 3:    pos = POS_W'($urandom_range(20, 0));
            default: pos = POS_W'($urandom_range(65535, 0));
        endcase
        send_cmd(pick_command(fill_mix), val, pos);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_QUERY;
        i_value         = '0;
        i_position      = '0;
        i_out_stall     = 1'b0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty set, a full set with a duplicate and a fresh value offered,
        // reads at both ends of the position range, misses and spare codes.
        send_cmd(CMD_PEEK, 8'h00, 16'h0000);
        send_cmd(CMD_TAKE, 8'h00, 16'hFFFF);
        send_cmd(CMD_DELETE, 8'h00, 16'h0000);
        for (int i = 0; i < CAPACITY; i++) send_cmd(CMD_ADD, 8'(i * 17), 16'h0000);
        send_cmd(CMD_ADD, 8'hFF, 16'h0000);
        send_cmd(CMD_ADD, 8'h80, 16'h0000);
        send_cmd(CMD_QUERY, 8'hFF, 16'h0000);
        send_cmd(CMD_QUERY, 8'h80, 16'h0000);
        send_cmd(CMD_PEEK, 8'h00, 16'hFFFF);
        send_cmd(CMD_TAKE, 8'h00, 16'h0000);
        send_cmd(CMD_DELETE, 8'hFF, 16'h0000);
        send_cmd(CMD_DELETE, 8'hFF, 16'h0000);
        send_cmd(CMD_RSVD_A, 8'h11, 16'h0001);
        send_cmd(CMD_RSVD_B, 8'h22, 16'h0002);
        send_cmd(CMD_CLEAR, 8'h00, 16'h0000);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 78;
                    sink_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 78;
                end
                default: begin
                    sender_idle_pct = 16;
                    sink_stall_pct  = 16;
                end
            endcase
            if (ph == 0) -> long_hold;
            for (int n = 0; n < PHASE_ITEMS; n++) send_random(n < PHASE_ITEMS / 2);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_insertion_ordered_set_core: PASS");
        end else begin
            $display("tb_insertion_ordered_set_core: FAIL");
        end
        $finish;
    end

endmodule
